>>> hdl/chained_hash_set_defines.svh
// ----------------------------------------------------------------------------
// chained_hash_set_defines
// Assertion macros for the chained hash set.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_SET_DEFINES_SVH
`define CHAINED_HASH_SET_DEFINES_SVH
`ifndef SYNTHESIS
`define CHS_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CHS_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHS_ASSERT_IMPL(label, clk, rst, prop, msg)
`define CHS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> hdl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Types and constants shared by the chained hash set.
// ----------------------------------------------------------------------------
`default_nettype none
package chs_pkg;
  localparam int BUCKETS = 256;
  localparam int NODES   = 1024;
  localparam int BW      = $clog2(BUCKETS);
  localparam int NW      = $clog2(NODES);
  localparam int LW      = NW + 1;       // link: node index or null
  localparam int CW      = 9;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [LW-1:0] NIL = LW'(NODES);

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] key_value;
  } chs_in_t;

  typedef struct packed {
    logic found;
    logic status;
  } chs_out_t;

  typedef struct packed {
    logic          start;
    logic [31:0]   dividend;
    logic [CW-1:0] divisor;
  } chs_div_req_t;
endpackage
`default_nettype wire

>>> hdl/chs_mod.sv
// ----------------------------------------------------------------------------
// chs_mod
// Bit-serial remainder of a 32-bit magnitude by the bucket count.
// ----------------------------------------------------------------------------
`default_nettype none
module chs_mod (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire chs_pkg::chs_div_req_t req,
  output logic                       done,
  output logic [chs_pkg::CW-1:0]     rem
);
  import chs_pkg::*;

  logic [31:0]   dvd;
  logic [CW-1:0] dvs;
  logic [5:0]    cnt;
  logic          run;
  logic [CW:0]   trial;
  logic [CW:0]   shifted;

  always_comb begin
    shifted = {rem, dvd[31]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      run  <= 1'b1;
      cnt  <= '0;
      dvd  <= req.dividend;
      dvs  <= req.divisor;
      rem  <= '0;
      done <= 1'b0;
    end else if (run) begin
      dvd  <= {dvd[30:0], 1'b0};
      rem  <= trial[CW] ? shifted[CW-1:0] : trial[CW-1:0];
      cnt  <= cnt + 6'd1;
      done <= (cnt == 6'd31);
      if (cnt == 6'd31) run <= 1'b0;
    end else begin
      done <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> hdl/chs_ram.sv
// ----------------------------------------------------------------------------
// chs_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module chs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 43
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> hdl/chained_hash_set.sv
// ----------------------------------------------------------------------------
// chained_hash_set
// Hash multiset of signed 32-bit keys with separate chaining.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from start until the result strobe, and a
// new item can be taken in the cycle that done is high. The bucket remainder
// comes from a bit-serial unit, one quotient bit a cycle, and the item waits
// in S_HASH until it is done. An insert that reuses a freed node passes
// through S_FREE_WAIT as well; a search or remove reads each chain node
// visited through S_NODE_RD and S_NODE_WAIT, since node memory has one port
// with a registered read, and a remove that hits passes S_FIX and S_RELEASE
// to unlink and free the node. An unused code goes from S_HASH to S_DONE.
// After reset a clearing pass empties the bucket heads; busy stays high
// meanwhile. Results cannot be held off: found/status are valid for the single cycle that done is high.
`default_nettype none
`include "chained_hash_set_defines.svh"
module chained_hash_set (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire chs_pkg::chs_in_t       item,
  output logic                        busy,
  output logic                        done,
  output chs_pkg::chs_out_t           result,
  input  wire logic                   cfg_we,
  input  wire logic [chs_pkg::CW-1:0] cfg_data
);
  import chs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD_RD, S_HEAD_WAIT, S_FREE_WAIT,
    S_NODE_RD, S_NODE_WAIT, S_FIX, S_RELEASE, S_DONE
  } state_t;

  state_t state;
  logic [CW-1:0] bucket_count;
  logic [CW-1:0] eff;
  logic [1:0]    func;
  logic [31:0]   key;
  logic [BW-1:0] bkt;
  logic [LW-1:0] cur, prev, free_head, alloc;
  logic [LW-1:0] fresh_count;
  logic [NW:0]   steps;
  logic          neg;
  // key of the previous node, kept for the rewrite of its link
  logic [31:0]   prev_key;

  chs_div_req_t  dreq;
  logic          ddone;
  logic [CW-1:0] drem;

  // bucket heads memory
  logic          h_we;
  logic [BW-1:0] h_addr;
  logic [LW-1:0] h_wdata, h_rdata;
  // node memory: {key, link}
  logic             n_we;
  logic [NW-1:0]    n_addr;
  logic [32+LW-1:0] n_wdata, n_rdata;
  logic [CW-1:0]    rsel;
  logic [LW-1:0]    n_link;

  assign eff    = (bucket_count == '0) ? CW'(1) :
                  (bucket_count > CW'(BUCKETS)) ? CW'(BUCKETS) : bucket_count;
  assign n_link = n_rdata[LW-1:0];
  assign busy   = (state != S_IDLE);

  always_comb begin
    rsel = (neg && drem != '0) ? eff - drem : drem;
  end

  chs_mod u_mod (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .rem(drem));

  chs_ram #(.DEPTH(BUCKETS), .WIDTH(LW)) u_heads (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));

  chs_ram #(.DEPTH(NODES), .WIDTH(32 + LW)) u_nodes (
    .clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wdata), .rdata(n_rdata));

  always_comb begin
    dreq.start    = (state == S_IDLE) && start;
    dreq.dividend = item.key_value[31] ? (~item.key_value + 32'd1) : item.key_value;
    dreq.divisor  = eff;
    h_we = 1'b0;  h_addr = bkt;  h_wdata = NIL;
    n_we = 1'b0;  n_addr = cur[NW-1:0];  n_wdata = {key, NIL};
    case (state)
      S_CLEAR: begin
        h_we = 1'b1;
      end
      S_HEAD_RD: begin
        n_addr = free_head[NW-1:0];  // fetch free-list link for insert
      end
      S_HEAD_WAIT: begin
        if (func == FUNC_INSERT && alloc != NIL) begin
          h_we = 1'b1;  h_wdata = alloc;
          n_we = 1'b1;  n_addr = alloc[NW-1:0];  n_wdata = {key, h_rdata};
        end
      end
      S_FIX: begin
        // cur matched; n_rdata still holds its entry
        if (prev == NIL) begin
          h_we = 1'b1;  h_wdata = n_link;
        end else begin
          n_we = 1'b1;  n_addr = prev[NW-1:0];  n_wdata = {prev_key, n_link};
        end
      end
      S_RELEASE: begin
        // freed node goes on top of the free list
        n_we = 1'b1;  n_wdata = {key, free_head};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      done         <= 1'b0;
      bucket_count <= CW'(BUCKETS);
      free_head    <= NIL;
      fresh_count  <= '0;
      bkt          <= '0;
    end else begin
      done <= (state == S_DONE);
      if (cfg_we) bucket_count <= cfg_data;
      case (state)
        S_CLEAR: begin
          bkt <= bkt + BW'(1);
          if (bkt == BW'(BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            func  <= item.func;
            key   <= item.key_value;
            neg   <= item.key_value[31];
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (ddone) begin
            bkt <= rsel[BW-1:0];
            if (func inside {FUNC_INSERT, FUNC_SEARCH, FUNC_REMOVE})
              state <= S_HEAD_RD;
            else begin
              result <= '0;  state <= S_DONE;
            end
          end
        end
        S_HEAD_RD: begin
          state <= (func == FUNC_INSERT && free_head != NIL) ? S_FREE_WAIT : S_HEAD_WAIT;
          if (free_head != NIL) alloc <= free_head;
          else if (fresh_count != NIL) alloc <= fresh_count;
          else alloc <= NIL;
        end
        S_FREE_WAIT: begin
          free_head <= n_link;
          state     <= S_HEAD_WAIT;
        end
        S_HEAD_WAIT: begin
          result <= '{found: 1'b0, status: (func == FUNC_INSERT && alloc == NIL)};
          if (func == FUNC_INSERT) begin
            if (alloc != NIL && alloc == fresh_count)
              fresh_count <= fresh_count + LW'(1);
            state <= S_DONE;
          end else begin
            cur   <= h_rdata;
            prev  <= NIL;
            steps <= '0;
            state <= (h_rdata == NIL) ? S_DONE : S_NODE_RD;
          end
        end
        S_NODE_RD: state <= S_NODE_WAIT;
        S_NODE_WAIT: begin
          if (n_rdata[32+LW-1:LW] == key) begin
            result.found <= 1'b1;
            state        <= (func == FUNC_REMOVE) ? S_FIX : S_DONE;
          end else begin
            prev     <= cur;
            prev_key <= n_rdata[32+LW-1:LW];
            cur      <= n_link;
            steps    <= steps + (NW+1)'(1);
            state    <= (n_link == NIL || steps == (NW+1)'(NODES - 1)) ? S_DONE : S_NODE_RD;
          end
        end
        S_FIX: begin
          state <= S_RELEASE;
        end
        S_RELEASE: begin
          free_head <= cur;
          state     <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHS_ASSERT_IMPL(a_busy_done, clk, rst, done |-> $past(busy), "done without busy")
  `CHS_ASSERT_IMPL(a_done_idle, clk, rst, done |-> !busy, "busy during done")
  `CHS_ASSERT_IMPL(a_start_busy, clk, rst, (start && !busy) |=> busy, "start not taken")
  `CHS_ASSERT_IMPL(a_drop_ins, clk, rst,
    (done && result.status) |-> (func == FUNC_INSERT && !result.found), "bad drop")
endmodule
`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chained hash set: random and directed
// insert/search/remove items against an in-bench model of the chains.
// ----------------------------------------------------------------------------
`default_nettype none

class hash_scoreboard;
  localparam int NB = chs_pkg::BUCKETS;
  localparam int NN = chs_pkg::NODES;
  int unsigned bucket_reg;
  int unsigned heads[NB];
  logic [31:0] keys[NN];
  int unsigned links[NN];
  int unsigned free_top;
  int unsigned fresh;
  chs_pkg::chs_out_t pending[$];
  int errors;

  function void clear();
    bucket_reg = 256;
    foreach (heads[i]) heads[i] = NN;
    free_top = NN;
    fresh = 0;
    pending.delete();
  endfunction

  function int unsigned bucket_index(logic [31:0] k);
    int unsigned n, r;
    n = bucket_reg;
    if (n < 1) n = 1;
    if (n > NB) n = NB;
    if (!k[31]) return k % n;
    r = (~k + 32'd1) % n;
    return (r == 0) ? 0 : n - r;
  endfunction

  function void note_item(chs_pkg::chs_in_t it);
    chs_pkg::chs_out_t o;
    int unsigned b, node, cur, prev, steps;
    logic [31:0] k;
    k = it.key_value;
    b = bucket_index(k);
    o = '0;
    if (it.func == chs_pkg::FUNC_INSERT) begin
      node = NN;
      if (free_top < NN) begin
        node = free_top;
        free_top = links[node];
      end else if (fresh < NN) begin
        node = fresh;
        fresh++;
      end
      if (node < NN) begin
        keys[node] = k;
        links[node] = heads[b];
        heads[b] = node;
      end else begin
        o.status = 1'b1;
      end
    end else if (it.func == chs_pkg::FUNC_SEARCH || it.func == chs_pkg::FUNC_REMOVE) begin
      cur = heads[b];
      prev = NN;
      steps = 0;
      while (cur < NN && steps < NN) begin
        if (keys[cur] == k) begin
          o.found = 1'b1;
          if (it.func == chs_pkg::FUNC_REMOVE) begin
            if (prev < NN) links[prev] = links[cur];
            else heads[b] = links[cur];
            links[cur] = free_top;
            free_top = cur;
          end
          break;
        end
        prev = cur;
        cur = links[cur];
        steps++;
      end
    end
    pending.push_back(o);
  endfunction

  function void check_result(chs_pkg::chs_out_t got);
    chs_pkg::chs_out_t want;
    if (pending.size() == 0) begin
      $error("unexpected result found=%0b status=%0b", got.found, got.status);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.found !== want.found) begin
      $error("found: expected %0b, actual %0b", want.found, got.found);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0b, actual %0b", want.status, got.status);
      errors++;
    end
  endfunction
endclass

module testbench;
  import chs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  chs_in_t item = '0;
  logic busy, done;
  chs_out_t result;
  logic cfg_we = 1'b0;
  logic [CW-1:0] cfg_data = '0;

  hash_scoreboard sb = new();
  int unsigned cycles = 0;
  int idle_pct = 13;
  logic [31:0] key_pool[16];

  chained_hash_set dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(result);
    if (cycles > 20000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(logic [1:0] f, logic [31:0] k);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    item <= '{func: f, key_value: k};
    do @(posedge clk); while (busy);
    sb.note_item('{func: f, key_value: k});
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_buckets(logic [CW-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.bucket_reg = v;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(3) != 0) return key_pool[$urandom_range(15)];
    return $urandom;
  endfunction

  task automatic random_ops(int count, int ins_weight);
    int w;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(99);
      if (w < ins_weight) send(FUNC_INSERT, pick_key());
      else if (w < ins_weight + (100 - ins_weight) / 2) send(FUNC_SEARCH, pick_key());
      else if (w < 98) send(FUNC_REMOVE, pick_key());
      else send(FUNC_UNUSED, pick_key());
    end
  endtask

  initial begin
    sb.clear();
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // busy stays high through the clearing pass
    repeat (300) @(posedge clk);

    // directed: extremes, duplicates, unused code, negative keys
    send(FUNC_SEARCH, 32'h0);
    send(FUNC_INSERT, 32'h8000_0000);
    send(FUNC_INSERT, 32'h7fff_ffff);
    send(FUNC_INSERT, 32'hffff_ffff);
    send(FUNC_INSERT, 32'hffff_ffff);
    send(FUNC_SEARCH, 32'h8000_0000);
    send(FUNC_SEARCH, 32'hffff_ffff);
    send(FUNC_REMOVE, 32'hffff_ffff);
    send(FUNC_SEARCH, 32'hffff_ffff);
    send(FUNC_REMOVE, 32'hffff_ffff);
    send(FUNC_REMOVE, 32'hffff_ffff);
    send(FUNC_UNUSED, 32'h7fff_ffff);
    send(FUNC_INSERT, 32'hffff_ff00);
    send(FUNC_SEARCH, 32'h0000_0100);
    // bucket count 0 acts as 1, above range acts as the max
    set_buckets(9'd0);
    send(FUNC_SEARCH, 32'h7fff_ffff);
    send(FUNC_INSERT, 32'h1234_5678);
    set_buckets(9'h1ff);
    send(FUNC_SEARCH, 32'h1234_5678);
    send(FUNC_SEARCH, 32'hffff_ff00);

    // no idling for a stretch
    idle_pct = 0;
    random_ops(100, 40);
    idle_pct = 13;
    set_buckets(9'd1);
    random_ops(30, 40);
    set_buckets(9'd7);
    random_ops(50, 40);
    set_buckets(9'd256);
    random_ops(30, 35);
    // fill the pool past capacity
    set_buckets(9'd200);
    for (int i = 0; i < 1040; i++) send(FUNC_INSERT, $urandom);
    random_ops(40, 30);
    set_buckets(9'd13);
    random_ops(40, 45);

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
